>>> rtl/pcd_pkg.sv
// Shared types and constants of the prefix code decoder.
`default_nettype none

package pcd_pkg;

   // Widths of the request and response fields.
   localparam int SYM_W      = 8;
   localparam int IN_CODE_W  = 32;
   localparam int LEN_W      = 6;
   localparam int REQ_DATA_W = 48;
   localparam int RSP_DATA_W = 8;

   // Request kinds carried in req_tuser.
   localparam logic MODE_LOAD   = 1'b0;
   localparam logic MODE_DECODE = 1'b1;

   // Response status carried in rsp_tuser.
   localparam logic STATUS_OK      = 1'b0;
   localparam logic STATUS_INVALID = 1'b1;

   // Sequencer states.
   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_SCAN = 3'b010,
      ST_EMIT = 3'b100
   } state_type;

endpackage : pcd_pkg

`default_nettype wire

>>> rtl/prefix_code_decoder_core.sv
// Top level of the prefix code decoder: table memory, scan sequencer and response register.
`default_nettype none

// Channel  Direction  Handshake              Contents
// req      in         req_tvalid/req_tready  tuser: mode; tdata: symbol, code, length, bit
// rsp      out        rsp_tvalid/rsp_tready  tuser: status; tdata: decoded symbol
//
// A load request writes its entry when it is accepted, and the block stays ready for more.
// A decode request scans the table and is then answered from the emit state, unless its
// code is still only a prefix of some entry; the single registered read port of the table
// memory and the one shared comparator walk the entries one per cycle. A scan stops early
// at the first full match. A decode request that meets the sticky error or a full partial
// code skips the scan and goes straight to the emit state. Reset is synchronous and clears
// the entry valid bits at once, so no clearing pass is needed. A stalled response holds the
// sequencer in its emit state, and no new request is taken until it has left.

module prefix_code_decoder_core #(
   parameter int NUM_SYMBOLS  = 256,
   parameter int MAX_CODE_LEN = 32
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   // Request channel.
   input  wire logic                           req_tvalid,
   output      logic                           req_tready,
   // Bits 7:0 symbol, 39:8 code_bits, 45:40 code_length, 46 bit_req, 47 zero.
   input  wire logic [pcd_pkg::REQ_DATA_W-1:0] req_tdata,
   // Bit 0 mode.
   input  wire logic                           req_tuser,
   // Response channel.
   output      logic                           rsp_tvalid,
   input  wire logic                           rsp_tready,
   // Bits 7:0 symbol_res.
   output      logic [pcd_pkg::RSP_DATA_W-1:0] rsp_tdata,
   // Bit 0 status.
   output      logic                           rsp_tuser
);

   import pcd_pkg::*;

   // The longest code that can be stored, and the width of a stored code word.
   localparam int LEN_CAP = (MAX_CODE_LEN < IN_CODE_W) ? MAX_CODE_LEN : IN_CODE_W;
   localparam int CODE_W  = LEN_CAP;
   localparam int IDX_W   = $clog2(NUM_SYMBOLS);
   localparam int ENTRY_W = LEN_W + CODE_W;

   localparam logic [LEN_W-1:0] LEN_CAP_V = LEN_W'(LEN_CAP);
   localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(NUM_SYMBOLS - 1);

   // Request fields.
   logic [SYM_W-1:0]     req_symbol;
   logic [IN_CODE_W-1:0] req_code_bits;
   logic [LEN_W-1:0]     req_code_length;
   logic                 req_bit;

   assign req_symbol      = req_tdata[7:0];
   assign req_code_bits   = req_tdata[39:8];
   assign req_code_length = req_tdata[45:40];
   assign req_bit         = req_tdata[46];

   // Sequencer and decoder state.
   state_type            state_ff, state_in;
   logic                 error_ff, error_in;
   logic [CODE_W-1:0]    partial_code_ff, partial_code_in;
   logic [LEN_W-1:0]     partial_len_ff, partial_len_in;

   // Candidate partial code of the decode request in progress and its compare mask.
   logic [CODE_W-1:0]    cand_code_ff, cand_code_in;
   logic [LEN_W-1:0]     cand_len_ff, cand_len_in;
   logic [CODE_W-1:0]    cand_mask_ff, cand_mask_in;
   logic                 any_prefix_ff, any_prefix_in;

   // Scan address generator and the read pipeline behind it.
   logic [IDX_W-1:0]     idx_ff, idx_in;
   logic                 issue_on_ff, issue_on_in;
   logic                 rd_vld_ff, rd_vld_in;
   logic [IDX_W-1:0]     rd_idx_ff, rd_idx_in;
   logic [ENTRY_W-1:0]   rd_data_ff;
   logic                 rd_written_ff;

   // Result waiting for the output register.
   logic [SYM_W-1:0]     res_sym_ff, res_sym_in;
   logic                 res_status_ff, res_status_in;

   // Output register.
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [SYM_W-1:0]     rsp_sym_ff, rsp_sym_in;
   logic                 rsp_status_ff, rsp_status_in;

   // Table memory, one entry per symbol holding length and code, and its written bits.
   logic [ENTRY_W-1:0]     table_mem [NUM_SYMBOLS];
   logic [NUM_SYMBOLS-1:0] written_ff;

   logic                 req_accept;
   logic                 load_go;
   logic [IDX_W-1:0]     load_addr;
   logic [LEN_W-1:0]     load_len;
   logic [CODE_W-1:0]    load_mask;
   logic [CODE_W-1:0]    load_code;

   logic [LEN_W-1:0]     next_len;
   logic [CODE_W-1:0]    next_code;
   logic [CODE_W-1:0]    next_mask;

   logic [LEN_W-1:0]     rd_len;
   logic [CODE_W-1:0]    rd_code;
   logic                 hit_prefix;
   logic                 hit_full;
   logic                 out_free;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_accept = req_tvalid && req_tready;

   // A load writes its entry in the cycle it is accepted; an out-of-range symbol is dropped.
   assign load_go   = req_accept && (req_tuser == MODE_LOAD)
                      && ({1'b0, req_symbol} < 9'(NUM_SYMBOLS));
   assign load_addr = req_symbol[IDX_W-1:0];
   assign load_len  = (req_code_length > LEN_CAP_V) ? LEN_CAP_V : req_code_length;
   assign load_mask = (load_len >= LEN_CAP_V) ? {CODE_W{1'b1}}
                                              : ~({CODE_W{1'b1}} << load_len);
   assign load_code = req_code_bits[CODE_W-1:0] & load_mask;

   // The new stream bit lands just above the bits collected so far.
   assign next_len  = partial_len_ff + LEN_W'(1);
   assign next_code = partial_code_ff | (CODE_W'(req_bit) << partial_len_ff);
   assign next_mask = (next_len >= LEN_CAP_V) ? {CODE_W{1'b1}}
                                              : ~({CODE_W{1'b1}} << next_len);

   // The shared comparator looks at one table entry per cycle.
   assign rd_len     = rd_data_ff[ENTRY_W-1:CODE_W];
   assign rd_code    = rd_data_ff[CODE_W-1:0];
   assign hit_prefix = rd_vld_ff && rd_written_ff && (rd_len != '0)
                       && (rd_len >= cand_len_ff)
                       && ((rd_code & cand_mask_ff) == cand_code_ff);
   assign hit_full   = hit_prefix && (rd_len == cand_len_ff);

   assign out_free = !rsp_valid_ff || rsp_tready;

   always_comb begin
      state_in        = state_ff;
      error_in        = error_ff;
      partial_code_in = partial_code_ff;
      partial_len_in  = partial_len_ff;
      cand_code_in    = cand_code_ff;
      cand_len_in     = cand_len_ff;
      cand_mask_in    = cand_mask_ff;
      any_prefix_in   = any_prefix_ff;
      idx_in          = idx_ff;
      issue_on_in     = 1'b0;
      rd_vld_in       = 1'b0;
      rd_idx_in       = idx_ff;
      res_sym_in      = res_sym_ff;
      res_status_in   = res_status_ff;
      rsp_valid_in    = rsp_valid_ff && !rsp_tready;
      rsp_sym_in      = rsp_sym_ff;
      rsp_status_in   = rsp_status_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               if (req_tuser == MODE_LOAD) begin
                  // A load that is taken restarts the code word; a dropped one changes nothing.
                  if (load_go) begin
                     partial_code_in = '0;
                     partial_len_in  = '0;
                  end
               end else if (error_ff || (partial_len_ff >= LEN_CAP_V)) begin
                  // Sticky error or a full partial code: invalid without a scan.
                  error_in      = 1'b1;
                  res_sym_in    = '0;
                  res_status_in = STATUS_INVALID;
                  state_in      = ST_EMIT;
               end else begin
                  cand_code_in  = next_code;
                  cand_len_in   = next_len;
                  cand_mask_in  = next_mask;
                  any_prefix_in = 1'b0;
                  idx_in        = '0;
                  issue_on_in   = 1'b1;
                  state_in      = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            // Issue the next table read while the previous entry is compared.
            issue_on_in = issue_on_ff && (idx_ff != LAST_IDX);
            rd_vld_in   = issue_on_ff;
            rd_idx_in   = idx_ff;
            if (issue_on_ff && (idx_ff != LAST_IDX)) begin
               idx_in = idx_ff + IDX_W'(1);
            end
            if (hit_prefix) begin
               any_prefix_in = 1'b1;
            end
            if (hit_full) begin
               // Ascending scan order makes the first full match the lowest symbol.
               partial_code_in = '0;
               partial_len_in  = '0;
               res_sym_in      = SYM_W'(rd_idx_ff);
               res_status_in   = STATUS_OK;
               issue_on_in     = 1'b0;
               rd_vld_in       = 1'b0;
               state_in        = ST_EMIT;
            end else if (rd_vld_ff && (rd_idx_ff == LAST_IDX)) begin
               if (any_prefix_ff || hit_prefix) begin
                  // Still a prefix of some code: keep the bit and wait for more.
                  partial_code_in = cand_code_ff;
                  partial_len_in  = cand_len_ff;
                  state_in        = ST_IDLE;
               end else begin
                  error_in      = 1'b1;
                  res_sym_in    = '0;
                  res_status_in = STATUS_INVALID;
                  state_in      = ST_EMIT;
               end
            end
         end
         ST_EMIT: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_sym_in    = res_sym_ff;
               rsp_status_in = res_status_ff;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         error_ff        <= 1'b0;
         partial_code_ff <= '0;
         partial_len_ff  <= '0;
         any_prefix_ff   <= 1'b0;
         issue_on_ff     <= 1'b0;
         rd_vld_ff       <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff        <= state_in;
         error_ff        <= error_in;
         partial_code_ff <= partial_code_in;
         partial_len_ff  <= partial_len_in;
         any_prefix_ff   <= any_prefix_in;
         issue_on_ff     <= issue_on_in;
         rd_vld_ff       <= rd_vld_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cand_code_ff  <= cand_code_in;
      cand_len_ff   <= cand_len_in;
      cand_mask_ff  <= cand_mask_in;
      idx_ff        <= idx_in;
      rd_idx_ff     <= rd_idx_in;
      res_sym_ff    <= res_sym_in;
      res_status_ff <= res_status_in;
      rsp_sym_ff    <= rsp_sym_in;
      rsp_status_ff <= rsp_status_in;
   end

   // Written bits: an entry never loaded reads as an unused symbol.
   always_ff @(posedge clock) begin
      if (reset) begin
         written_ff <= '0;
      end else if (load_go) begin
         written_ff[load_addr] <= 1'b1;
      end
   end

   // Table memory with one write port and one registered read port.
   always_ff @(posedge clock) begin
      if (load_go) begin
         table_mem[load_addr] <= {load_len, load_code};
      end
      rd_data_ff    <= table_mem[idx_ff];
      rd_written_ff <= written_ff[idx_ff];
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_sym_ff;
   assign rsp_tuser  = rsp_status_ff;

`ifndef SYNTHESIS
   // The error flag is sticky until reset.
   a_error_sticky: assert property (@(posedge clock) disable iff (reset)
      error_ff |=> error_ff)
      else $error("error flag cleared without reset");

   // An invalid response is only ever shown once the error flag is set.
   a_invalid_has_error: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_status_ff == STATUS_INVALID)) |-> error_ff)
      else $error("invalid response without error flag");

   // A decoded symbol is always a real table index.
   a_symbol_in_range: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_status_ff == STATUS_OK)) |-> (rsp_sym_ff < 9'(NUM_SYMBOLS)))
      else $error("decoded symbol out of range");

   // During a scan either reads are still issued or the last one is being compared.
   a_scan_progress: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) |-> (issue_on_ff || rd_vld_ff))
      else $error("scan stalled with nothing in flight");

   // The collected code never grows beyond the longest storable code.
   a_partial_bound: assert property (@(posedge clock) disable iff (reset)
      partial_len_ff <= LEN_CAP_V)
      else $error("partial code length beyond cap");
`endif

endmodule : prefix_code_decoder_core

`default_nettype wire
